// ===== design/ita_pkg.sv =====
package ita_pkg;

   // Field widths fixed by the request and result formats
   localparam int BASE_W              = 6;
   localparam int CHAR_W              = 8;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // Radix limits and the one radix that carries a sign
   localparam logic [BASE_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [BASE_W-1:0] RADIX_MAX     = 6'd36;
   localparam logic [BASE_W-1:0] RADIX_DECIMAL = 6'd10;

   // ASCII codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

   // Bring any requested radix into 2..36
   function automatic logic [BASE_W-1:0] clamp_radix(input logic [BASE_W-1:0] r);
      logic [BASE_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) res = RADIX_MIN;
      if (r > RADIX_MAX) res = RADIX_MAX;
      return res;
   endfunction

   // Digit value to its ASCII character
   function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < RADIX_DECIMAL) begin
         res = CHAR_ZERO + {2'b00, d};
      end else begin
         res = CHAR_LOW_A + {2'b00, d} - {2'b00, RADIX_DECIMAL};
      end
      return res;
   endfunction

endpackage

// ===== design/ita_if.sv =====
interface ita_req_if import ita_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) ();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic [BASE_W-1:0]      base;
   logic                   kind;

   modport source (output valid, value, base, kind, input ready);
   modport sink   (input valid, value, base, kind, output ready);
endinterface

interface ita_rsp_if import ita_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, char_out, last, input ready);
   modport sink   (input valid, char_out, last, output ready);
endinterface

// ===== design/integer_to_ascii_radix.sv =====
// Integer to ASCII text in a radix of 2..36.
//
// req_chan carries one request: value, base (clamped into 2..36) and kind
// (1 = signed, which only matters in base 10). rsp_chan returns the text one
// character a beat, most significant digit first, last set on the final one.
// A negative signed decimal value is sent as '-' and then its magnitude.
//
// Digits come from a bit-serial divider: each digit takes one load and VALUE_WIDTH
// shift/subtract steps; a '-' adds the S_SIGN state. Digits are stored least
// significant first and then read back in reverse, each character through a
// memory read (S_READ) and then presentation (S_SHOW).
// One request is worked at a time; req_chan.ready is high only when idle.
//
// Reset (synchronous) returns the block to idle with no character pending.
// A stalled receiver holds the current character.
module integer_to_ascii_radix import ita_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   ita_req_if.sink   req_chan,
   ita_rsp_if.source rsp_chan
);

   localparam int DEPTH  = VALUE_WIDTH + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SIGN,
      S_READ,
      S_SHOW
   } state_type;

   state_type         state_ff, state_in;
   logic [BASE_W-1:0] radix_ff, radix_in;
   logic              neg_ff, neg_in;
   logic [ADDR_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;

   logic                   req_fire;
   logic [BASE_W-1:0]      req_radix;
   logic                   req_neg;
   logic [VALUE_WIDTH-1:0] req_mag;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [BASE_W-1:0]      div_remainder;

   logic                   wr_en;
   logic [CHAR_W-1:0]      wr_data;
   logic                   rd_en;
   logic [CHAR_W-1:0]      rd_data;

   // Request decode: clamp the radix, take the magnitude of negative decimals
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign req_radix = clamp_radix(req_chan.base);
   assign req_neg   = req_chan.kind && (req_radix == RADIX_DECIMAL)
                      && req_chan.value[VALUE_WIDTH-1];
   assign req_mag   = req_neg ? (~req_chan.value + 1'b1) : req_chan.value;

   ita_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ita_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Sequencer: divide out digits, append sign, then read back in reverse
   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      div_start    = 1'b0;
      div_dividend = div_quotient;
      wr_en        = 1'b0;
      wr_data      = digit_char(div_remainder);
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            div_dividend = req_mag;
            if (req_fire) begin
               div_start = 1'b1;
               radix_in  = req_radix;
               neg_in    = req_neg;
               count_in  = '0;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_quotient != '0) begin
                  div_start = 1'b1;
               end else if (neg_ff) begin
                  state_in = S_SIGN;
               end else begin
                  idx_in   = count_ff;
                  state_in = S_READ;
               end
            end
         end
         S_SIGN: begin
            wr_en    = 1'b1;
            wr_data  = CHAR_MINUS;
            count_in = count_ff + 1'b1;
            idx_in   = count_ff;
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_SHOW;
         end
         S_SHOW: begin
            if (rsp_chan.ready) begin
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshakes and response payload
   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = (state_ff == S_SHOW);
   assign rsp_chan.char_out = rd_data;
   assign rsp_chan.last     = (idx_ff == '0);

endmodule

// ===== design/ita_divider.sv =====
// Bit-serial restoring divider: divides by a 6-bit radix, one dividend bit per cycle.
module ita_divider import ita_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [BASE_W-1:0]      radix,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient,
   output logic [BASE_W-1:0]      remainder
);

   localparam int STEP_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [BASE_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [BASE_W:0]        trial;
   logic                   fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits  = (trial >= {1'b0, radix});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? BASE_W'(trial - {1'b0, radix}) : trial[BASE_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/ita_store.sv =====
// Character store: one write port, one read port with registered data.
module ita_store import ita_pkg::*; #(
   parameter int DEPTH  = DEFAULT_VALUE_WIDTH + 1,
   parameter int ADDR_W = $clog2(DEFAULT_VALUE_WIDTH + 1)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CHAR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CHAR_W-1:0] rd_data
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench import ita_pkg::*; ();

   localparam int VW = DEFAULT_VALUE_WIDTH;

   // One conversion request; drain holds it back until all text has returned
   typedef struct {
      logic [VW-1:0]     value;
      logic [BASE_W-1:0] base;
      logic              kind;
      bit                drain;
   } conv_req_type;

   // One character of expected text
   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } text_char_type;

   logic clock;
   logic reset;

   ita_req_if #(.VALUE_WIDTH(VW)) req_chan ();
   ita_rsp_if                     rsp_chan ();

   integer_to_ascii_radix #(.VALUE_WIDTH(VW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   conv_req_type  request_q[$];
   text_char_type expected_chars[$];

   int unsigned accepted_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned hold_left      = 0;
   bit          hold_done      = 0;
   bit          req_fired      = 0;
   logic        calm;

   // Long window with no idling on either side
   assign calm = (accepted_count >= 200) && (accepted_count < 280);

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Expected text for one request, most significant character first
   function automatic void predict_text(input conv_req_type r);
      int unsigned       radix;
      logic [VW-1:0]     mag;
      logic [VW-1:0]     digit;
      logic [CHAR_W-1:0] ch;
      logic [CHAR_W-1:0] text[$];
      bit                neg;
      text_char_type     e;
      radix = r.base;
      if (radix < RADIX_MIN) radix = RADIX_MIN;
      if (radix > RADIX_MAX) radix = RADIX_MAX;
      neg = r.kind && (radix == RADIX_DECIMAL) && r.value[VW-1];
      mag = neg ? (~r.value + 1'b1) : r.value;
      do begin
         digit = mag % radix;
         mag   = mag / radix;
         if (digit < RADIX_DECIMAL) ch = CHAR_ZERO + CHAR_W'(digit);
         else ch = CHAR_LOW_A + CHAR_W'(digit - RADIX_DECIMAL);
         text.push_front(ch);
      end while (mag != 0);
      if (neg) text.push_front(CHAR_MINUS);
      foreach (text[i]) begin
         e.ch   = text[i];
         e.last = (i == text.size() - 1);
         expected_chars.push_back(e);
      end
   endfunction

   // Values that favor the interesting corners of the number range
   function automatic logic [VW-1:0] rand_value();
      logic [63:0]   wide;
      logic [VW-1:0] v;
      int unsigned   k;
      wide = {$urandom, $urandom};
      k    = $urandom_range(0, VW - 1);
      case ($urandom_range(0, 7))
         0: v = VW'($urandom_range(0, 40));
         1: begin
            v = VW'(1) << k;
            if ($urandom_range(0, 1)) v = v - 1'b1;
         end
         2: begin
            if ($urandom_range(0, 1)) v = ({1'b1, {(VW-1){1'b0}}}) + VW'($urandom_range(0, 3));
            else v = '1 - VW'($urandom_range(0, 3));
         end
         default: v = wide[VW-1:0];
      endcase
      return v;
   endfunction

   // Radix: decimal and hex often, otherwise anything the field can carry
   function automatic logic [BASE_W-1:0] rand_base();
      logic [BASE_W-1:0] b;
      case ($urandom_range(0, 9))
         0, 1, 2: b = RADIX_DECIMAL;
         3:       b = 6'd16;
         default: b = BASE_W'($urandom_range(0, 63));
      endcase
      return b;
   endfunction

   task automatic add_req(input logic [VW-1:0] value, input logic [BASE_W-1:0] base,
                          input logic kind, input bit drain = 0);
      conv_req_type r;
      r.value = value;
      r.base  = base;
      r.kind  = kind;
      r.drain = drain;
      request_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endtask

   // Request driver: new requests go out at the falling edge
   always @(negedge clock) begin : drive_requests
      conv_req_type nxt;
      bit           launch;
      launch = 0;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (request_q.size() != 0) begin
            launch = (calm || $urandom_range(0, 99) >= 30) &&
                     !(request_q[0].drain && expected_chars.size() != 0);
         end
         if (launch) begin
            nxt = request_q.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.value <= nxt.value;
            req_chan.base  <= nxt.base;
            req_chan.kind  <= nxt.kind;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Accepted requests feed the predictor
   always @(posedge clock) begin : take_requests
      conv_req_type r;
      req_fired <= !reset && req_chan.valid && req_chan.ready;
      if (!reset && req_chan.valid && req_chan.ready) begin
         r.value = req_chan.value;
         r.base  = req_chan.base;
         r.kind  = req_chan.kind;
         r.drain = 0;
         predict_text(r);
         accepted_count <= accepted_count + 1;
      end
   end

   // Long receiver hold-off while the sender keeps offering
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_count == 40) begin
         hold_left <= 600;
         hold_done <= 1;
      end
   end

   // Receiver ready
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && (hold_left == 0) && (calm || $urandom_range(0, 99) >= 30);
   end

   // Character checker
   always @(posedge clock) begin : check_text
      text_char_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h last %b",
                                      rsp_chan.char_out, rsp_chan.last));
         end else begin
            e = expected_chars.pop_front();
            if (rsp_chan.char_out !== e.ch || rsp_chan.last !== e.last) begin
               report_mismatch($sformatf("expected char %h last %b, got char %h last %b",
                                         e.ch, e.last, rsp_chan.char_out, rsp_chan.last));
            end
         end
      end
   end

   // Timeout
   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      req_chan.base  = '0;
      req_chan.kind  = 1'b0;
      rsp_chan.ready = 1'b0;
      reset          = 1'b1;

      // Directed: zero, extremes, sign handling, radix clamping
      add_req('0, RADIX_DECIMAL, 1'b0);
      add_req('0, RADIX_MIN, 1'b0);
      add_req('0, RADIX_MAX, 1'b1);
      add_req('1, RADIX_MIN, 1'b0);
      add_req('1, 6'd16, 1'b0);
      add_req('1, RADIX_DECIMAL, 1'b1);
      add_req('1, 6'd8, 1'b1);
      add_req({1'b1, {(VW-1){1'b0}}}, RADIX_DECIMAL, 1'b1);
      add_req({1'b1, {(VW-1){1'b0}}}, RADIX_DECIMAL, 1'b0);
      add_req({1'b0, {(VW-1){1'b1}}}, RADIX_DECIMAL, 1'b1);
      add_req(VW'(35), RADIX_MAX, 1'b0);
      add_req(VW'(36), RADIX_MAX, 1'b0);
      add_req(VW'(10), 6'd11, 1'b0);
      add_req(VW'(1234567890), RADIX_DECIMAL, 1'b0);
      add_req(-VW'(12345), RADIX_DECIMAL, 1'b1);
      add_req(-VW'(12345), 6'd16, 1'b1);
      add_req(VW'(100), RADIX_DECIMAL, 1'b1);
      add_req(VW'(255), 6'd0, 1'b0);
      add_req(VW'(255), 6'd1, 1'b1);
      add_req(VW'(12345), 6'd37, 1'b0);
      add_req('1, 6'd63, 1'b1);
      add_req('1, 6'd3, 1'b0);

      // Random part, twice pausing until all text is back
      for (int i = 0; i < 388; i++) begin
         add_req(rand_value(), rand_base(), 1'($urandom_range(0, 1)), (i == 100) || (i == 250));
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Checked at the rising edge, where the driver's outputs are settled
      while (request_q.size() != 0 || req_chan.valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (50) @(negedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
